FILE: rtl/core/kcs_pkg.sv
// shared types, constants and field positions of the keyframe curve sampler
package kcs_pkg;

	// default store size in halfwords, a power of two
	localparam int KCS_STORE_HALFWORDS_DEF = 4096;

	// curve info word fields
	localparam int INFO_QUARTER_BIT = 31;
	localparam int INFO_HALF_BIT    = 30;
	localparam int INFO_CONST_BIT   = 29;
	localparam int INFO_SHORT_BIT   = 28;
	localparam int INFO_LAST_W      = 16;

	// entry index width: one bit more than a 16-bit frame
	localparam int IDX_W = 17;

	// wide sum: 3 * near + far of 32-bit entries
	localparam int SUM_W = 35;

	// read ports of the store copies
	localparam int RD_PORTS = 4;
	localparam int RP_A_LO  = 0;
	localparam int RP_A_HI  = 1;
	localparam int RP_B_LO  = 2;
	localparam int RP_B_HI  = 3;

	typedef enum logic [2:0] {
		OP_ZERO,
		OP_CONST,
		OP_ONE,
		OP_MEAN,
		OP_WEIGHT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic is_short;
	} rd_cmd_t;

endpackage

FILE: rtl/core/kcs_ram.sv
// generic single write, single read ram with registered read data
module kcs_ram
	import kcs_pkg::*;
#(
	parameter int WIDTH = 16,
	parameter int DEPTH = KCS_STORE_HALFWORDS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/kcs_decode.sv
// curve mode decode and halfword read address generation
module kcs_decode
	import kcs_pkg::*;
#(
	parameter int AW = $clog2(KCS_STORE_HALFWORDS_DEF)
) (
	input  logic          kind,
	input  logic [31:0]   curve_info,
	input  logic [31:0]   const_or_offset,
	input  logic [15:0]   frame,
	output rd_cmd_t       cmd,
	output logic [AW-1:0] addr_a_lo,
	output logic [AW-1:0] addr_a_hi,
	output logic [AW-1:0] addr_b_lo,
	output logic [AW-1:0] addr_b_hi
);

	logic [INFO_LAST_W-1:0] last;
	logic                   past_last;
	logic [IDX_W-1:0]       h_idx;
	logic [IDX_W-1:0]       q_idx;
	logic [IDX_W-1:0]       idx_a;
	logic [IDX_W-1:0]       idx_b;
	logic [IDX_W:0]         off_a;
	logic [IDX_W:0]         off_b;
	logic [AW-1:0]          base;

	always_comb begin
		last         = curve_info[INFO_LAST_W-1:0];
		past_last    = frame > last;
		h_idx        = IDX_W'(frame[15:1]);
		q_idx        = IDX_W'(frame[15:2]);
		cmd.op       = OP_ONE;
		cmd.is_short = curve_info[INFO_SHORT_BIT];
		idx_a        = IDX_W'(frame);
		idx_b        = '0;

		if (!kind) begin
			cmd.op = OP_ZERO;
		end else if (curve_info[INFO_CONST_BIT]) begin
			cmd.op = OP_CONST;
		end else if (!curve_info[INFO_HALF_BIT] && !curve_info[INFO_QUARTER_BIT]) begin
			idx_a = IDX_W'(frame);
		end else if (curve_info[INFO_HALF_BIT]) begin
			// half rate wins when both rate bits are set
			if (!frame[0]) begin
				idx_a = h_idx;
			end else if (past_last) begin
				idx_a = IDX_W'(last[15:1]) + IDX_W'(1);
			end else begin
				cmd.op = OP_MEAN;
				idx_a  = h_idx;
				idx_b  = h_idx + IDX_W'(1);
			end
		end else begin
			if (frame[1:0] == 2'b00) begin
				idx_a = q_idx;
			end else if (past_last) begin
				idx_a = IDX_W'(frame[1:0]) + IDX_W'(last[15:2]);
			end else if (frame[0]) begin
				// near key gets weight three
				cmd.op = OP_WEIGHT;
				if (frame[1]) begin
					idx_a = q_idx + IDX_W'(1);
					idx_b = q_idx;
				end else begin
					idx_a = q_idx;
					idx_b = q_idx + IDX_W'(1);
				end
			end else begin
				cmd.op = OP_MEAN;
				idx_a  = q_idx;
				idx_b  = q_idx + IDX_W'(1);
			end
		end

		off_a = cmd.is_short ? {1'b0, idx_a} : {idx_a, 1'b0};
		off_b = cmd.is_short ? {1'b0, idx_b} : {idx_b, 1'b0};
	end

	// byte offset to halfword address, low bit dropped, wraps with the store
	assign base      = const_or_offset[AW:1];
	assign addr_a_lo = base + off_a[AW-1:0];
	assign addr_a_hi = addr_a_lo + AW'(1);
	assign addr_b_lo = base + off_b[AW-1:0];
	assign addr_b_hi = addr_b_lo + AW'(1);

endmodule

FILE: rtl/core/keyframe_curve_sampler.sv
// keyframe curve sampler top level: five stage pipeline around a replicated halfword store
//
// usage
//   request channel (req_valid / req_stall) carries one word per item: kind 0 writes
//   write_data to halfword write_address of the store, kind 1 samples a curve given by
//   curve_info, const_or_offset and frame
//   response channel (rsp_valid / rsp_stall) returns one value word per request, in
//   request order; write requests answer zero
//   an accepted word passes in turn the request, decode, store read, sum and response registers
//   throughput: one word per cycle while req_stall is low, set by the five register
//   stages and four store copies, so both 32-bit keys of a sample are read in the same cycle
//   writes and reads hit the store in the same stage, so a sample sees every earlier write
//   reset clears all stage valid bits; the store content stays undefined until written
//   a stalled response holds its word; stages behind it keep filling, and req_stall only
//   rises when all five stages hold a word and the response is stalled
//   STORE_HALFWORDS must be a power of two; addresses wrap modulo the store size
module keyframe_curve_sampler
	import kcs_pkg::*;
#(
	parameter int STORE_HALFWORDS = KCS_STORE_HALFWORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               kind,
	input  logic [11:0]        write_address,
	input  logic [15:0]        write_data,
	input  logic [31:0]        curve_info,
	input  logic [31:0]        const_or_offset,
	input  logic [15:0]        frame,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] value
);

	localparam int AW = $clog2(STORE_HALFWORDS);

	// stage valid bits and load enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5;

	// stage 1: request register
	logic        kind_s1;
	logic [11:0] waddr_s1;
	logic [15:0] wdata_s1;
	logic [31:0] info_s1;
	logic [31:0] offs_s1;
	logic [15:0] frame_s1;

	// stage 2: decoded command and store addresses
	rd_cmd_t       cmd_nxt;
	logic [AW-1:0] raddr_nxt [RD_PORTS];
	logic [AW+11:0] waddr_ext;
	rd_cmd_t       cmd_s2;
	logic [31:0]   const_s2;
	logic [AW-1:0] raddr_s2 [RD_PORTS];
	logic [AW-1:0] waddr_s2;
	logic [15:0]   wdata_s2;

	// stage 3: store read data (inside the rams) plus command
	logic          ram_re;
	logic          ram_we;
	logic [15:0]   rdata_s3 [RD_PORTS];
	rd_cmd_t       cmd_s3;
	logic [31:0]   const_s3;
	logic signed [31:0]      ent_a;
	logic signed [31:0]      ent_b;
	logic signed [SUM_W-1:0] ent_a_x;
	logic signed [SUM_W-1:0] ent_b_x;
	logic signed [SUM_W-1:0] const_x;
	logic signed [SUM_W-1:0] sum_nxt;

	// stage 4: wide sum
	op_t                     op_s4;
	logic signed [SUM_W-1:0] sum_s4;
	logic signed [SUM_W-1:0] sum_sh;

	// stage 5: response register
	logic signed [31:0] value_s5;

	// each stage loads when empty or when the one after it moves
	assign ld_s5     = !vld_s5 || !rsp_stall;
	assign ld_s4     = !vld_s4 || ld_s5;
	assign ld_s3     = !vld_s3 || ld_s4;
	assign ld_s2     = !vld_s2 || ld_s3;
	assign ld_s1     = !vld_s1 || ld_s2;
	assign req_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (ld_s1) begin
				vld_s1 <= req_valid;
			end
			if (ld_s2) begin
				vld_s2 <= vld_s1;
			end
			if (ld_s3) begin
				vld_s3 <= vld_s2;
			end
			if (ld_s4) begin
				vld_s4 <= vld_s3;
			end
			if (ld_s5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	// mode decode and address generation between stage 1 and stage 2
	kcs_decode #(
		.AW (AW)
	) u_decode (
		.kind            (kind_s1),
		.curve_info      (info_s1),
		.const_or_offset (offs_s1),
		.frame           (frame_s1),
		.cmd             (cmd_nxt),
		.addr_a_lo       (raddr_nxt[RP_A_LO]),
		.addr_a_hi       (raddr_nxt[RP_A_HI]),
		.addr_b_lo       (raddr_nxt[RP_B_LO]),
		.addr_b_hi       (raddr_nxt[RP_B_HI])
	);

	// write address wraps modulo the store size
	assign waddr_ext = {{AW{1'b0}}, waddr_s1};

	// store copies: every write goes to all four, each serves one read address;
	// reads and writes both happen as stage 2 moves on, so item order is kept
	assign ram_re = ld_s3 && vld_s2;
	assign ram_we = ram_re && (cmd_s2.op == OP_ZERO);

	for (genvar g = 0; g < RD_PORTS; g++) begin : g_store
		kcs_ram #(
			.WIDTH (16),
			.DEPTH (STORE_HALFWORDS)
		) u_ram (
			.clk   (clk),
			.we    (ram_we),
			.waddr (waddr_s2),
			.wdata (wdata_s2),
			.re    (ram_re),
			.raddr (raddr_s2[g]),
			.rdata (rdata_s3[g])
		);
	end

	// key values: short entries sign-extend, long entries are two little-endian halfwords
	always_comb begin
		ent_a   = cmd_s3.is_short ? {{16{rdata_s3[RP_A_LO][15]}}, rdata_s3[RP_A_LO]}
		                          : {rdata_s3[RP_A_HI], rdata_s3[RP_A_LO]};
		ent_b   = cmd_s3.is_short ? {{16{rdata_s3[RP_B_LO][15]}}, rdata_s3[RP_B_LO]}
		                          : {rdata_s3[RP_B_HI], rdata_s3[RP_B_LO]};
		ent_a_x = {{(SUM_W-32){ent_a[31]}}, ent_a};
		ent_b_x = {{(SUM_W-32){ent_b[31]}}, ent_b};
		const_x = {{(SUM_W-32){const_s3[31]}}, const_s3};
		case (cmd_s3.op)
			OP_ZERO:   sum_nxt = '0;
			OP_CONST:  sum_nxt = const_x;
			OP_ONE:    sum_nxt = ent_a_x;
			OP_MEAN:   sum_nxt = ent_a_x + ent_b_x;
			OP_WEIGHT: sum_nxt = (ent_a_x <<< 1) + ent_a_x + ent_b_x;
			default:   sum_nxt = '0;
		endcase
	end

	// arithmetic shift rounds toward minus infinity
	always_comb begin
		case (op_s4)
			OP_MEAN:   sum_sh = sum_s4 >>> 1;
			OP_WEIGHT: sum_sh = sum_s4 >>> 2;
			default:   sum_sh = sum_s4;
		endcase
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (ld_s1 && req_valid) begin
			kind_s1  <= kind;
			waddr_s1 <= write_address;
			wdata_s1 <= write_data;
			info_s1  <= curve_info;
			offs_s1  <= const_or_offset;
			frame_s1 <= frame;
		end
		if (ld_s2 && vld_s1) begin
			cmd_s2   <= cmd_nxt;
			const_s2 <= offs_s1;
			raddr_s2 <= raddr_nxt;
			waddr_s2 <= waddr_ext[AW-1:0];
			wdata_s2 <= wdata_s1;
		end
		if (ld_s3 && vld_s2) begin
			cmd_s3   <= cmd_s2;
			const_s3 <= const_s2;
		end
		if (ld_s4 && vld_s3) begin
			op_s4  <= cmd_s3.op;
			sum_s4 <= sum_nxt;
		end
		if (ld_s5 && vld_s4) begin
			value_s5 <= sum_sh[31:0];
		end
	end

	assign rsp_valid = vld_s5;
	assign value     = value_s5;

	// input only blocks when every stage holds a word
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && rsp_stall))
		else $error("request stalled with a free pipeline stage");

	// an empty response register never blocks the request side
	assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled while response register is empty");

	// write words leave the arithmetic stage as zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(ld_s4 && vld_s3 && (cmd_s3.op == OP_ZERO)) |=> (sum_s4 == '0))
		else $error("write word produced a nonzero sum");

	// constant mode passes the offset word through unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		(ld_s4 && vld_s3 && (cmd_s3.op == OP_CONST)) |=> (sum_s4[31:0] == $past(const_s3)))
		else $error("constant mode value altered");

endmodule
